/* rtl/gpio_port_with_open_drain_pulls_unit_defines.svh */
// Assertion macros shared by the port RTL.
`ifndef GPIO_PORT_WITH_OPEN_DRAIN_PULLS_UNIT_DEFINES_SVH
`define GPIO_PORT_WITH_OPEN_DRAIN_PULLS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property, held off while reset is low.
`define GP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gpio port assertion failed");
// Check a property on every edge, reset included.
`define GP_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("gpio port assertion failed");
`else
`define GP_ASSERT(name, clk, rst_n, prop)
`define GP_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

/* rtl/gpodp_pkg.sv */
`default_nettype none

package gpodp_pkg;

    typedef enum logic [1:0] {
        CMD_READ       = 2'd0,
        CMD_WRITE      = 2'd1,
        CMD_DRIVE      = 2'd2,
        CMD_DISCONNECT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_OFF   = 2'd1,
        ST_REFUSED   = 2'd2,
        ST_RESERVED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_MODE_RST  = 2'd0,
        CFG_SPEED_RST = 2'd1,
        CFG_PULL_RST  = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    localparam logic [9:0] OFF_MODE   = 10'h000;
    localparam logic [9:0] OFF_OTYPE  = 10'h004;
    localparam logic [9:0] OFF_SPEED  = 10'h008;
    localparam logic [9:0] OFF_PULL   = 10'h00C;
    localparam logic [9:0] OFF_INPUT  = 10'h010;
    localparam logic [9:0] OFF_OUTPUT = 10'h014;
    localparam logic [9:0] OFF_BSRR   = 10'h018;
    localparam logic [9:0] OFF_LOCK   = 10'h01C;
    localparam logic [9:0] OFF_AFL    = 10'h020;
    localparam logic [9:0] OFF_AFH    = 10'h024;
    localparam logic [9:0] OFF_BRR    = 10'h028;
    localparam logic [9:0] OFF_ASCR   = 10'h02C;

    localparam logic [1:0] MODE_OUTPUT = 2'b01;
    localparam logic [1:0] PULL_UP     = 2'b01;
    localparam logic [1:0] PULL_DOWN   = 2'b10;

    typedef struct packed {
        t_cmd        cmd;
        logic [9:0]  reg_offset;
        logic [31:0] write_data;
        logic [3:0]  pin_line;
        logic        pin_level;
        logic [15:0] disconnect_mask;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] rise_pins;
        logic [15:0] fall_pins;
        t_status     status;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/gpio_port_with_open_drain_pulls_unit.sv */
// GPIO port of up to 16 pins with open-drain outputs and pull resistors. Each
// request is a bus read, a bus write, an external drive of one pin or a mask
// of pins to disconnect; its result is loaded into the output register at the
// same edge that accepts it, so one request per cycle goes through when the
// result side takes results as they come. The result register is the only
// stage: a new request is accepted whenever no result is pending or the
// pending result is taken in the same cycle. A write to the configuration
// port with any index but CFG_NONE reloads the whole port state from the
// stored reset values.
`default_nettype none

`include "gpio_port_with_open_drain_pulls_unit_defines.svh"

module gpio_port_with_open_drain_pulls_unit
    import gpodp_pkg::*;
#(
    parameter int NUM_PINS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata
);

    localparam logic [15:0] PinMask = 16'((32'd1 << NUM_PINS) - 32'd1);

    // resolve every pin's input level; a floating pin with no pull keeps its old bit
    function automatic logic [15:0] f_refresh(
        input logic [31:0] mode,
        input logic [15:0] otype,
        input logic [31:0] pull,
        input logic [15:0] outb,
        input logic [15:0] flt,
        input logic [15:0] dh,
        input logic [15:0] old
    );
        logic [15:0] val;
        logic [1:0]  pl;
        logic        ext;
        val = old;
        for (int p = 0; p < 16; p++) begin
            pl  = pull[2*p +: 2];
            ext = !flt[p];
            if (p < NUM_PINS) begin
                if (mode[2*p +: 2] == MODE_OUTPUT) begin
                    if (!otype[p] || !outb[p]) begin
                        val[p] = outb[p];
                    end else if (ext && !dh[p]) begin
                        val[p] = 1'b0;
                    end else if (pl == PULL_UP) begin
                        val[p] = 1'b1;
                    end else if (pl == PULL_DOWN) begin
                        val[p] = 1'b0;
                    end
                end else if (ext) begin
                    val[p] = dh[p];
                end else if (pl == PULL_UP) begin
                    val[p] = 1'b1;
                end else if (pl == PULL_DOWN) begin
                    val[p] = 1'b0;
                end
            end
        end
        return val;
    endfunction

    // externally driven output pins that would fight the port
    function automatic logic [15:0] f_conflicts(
        input logic [31:0] mode,
        input logic [15:0] otype,
        input logic [15:0] flt,
        input logic [15:0] dh
    );
        logic [15:0] m;
        m = '0;
        for (int p = 0; p < 16; p++) begin
            if (p < NUM_PINS && !flt[p] && mode[2*p +: 2] == MODE_OUTPUT
                && (!otype[p] || dh[p])) begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

    logic [31:0] r_mode_rv, r_speed_rv, r_pull_rv;
    logic [31:0] r_mode, n_mode;
    logic [15:0] r_otype, n_otype;
    logic [31:0] r_speed, n_speed;
    logic [31:0] r_pull, n_pull;
    logic [15:0] r_input, n_input;
    logic [15:0] r_output, n_output;
    logic [15:0] r_lock, n_lock;
    logic [31:0] r_afl, n_afl;
    logic [31:0] r_afh, n_afh;
    logic [15:0] r_ascr, n_ascr;
    logic [15:0] r_float, n_float;
    logic [15:0] r_dh, n_dh;
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        in_acc;
    logic        upd;
    logic [15:0] pin_bit;
    logic [31:0] cfg_mode, cfg_speed, cfg_pull;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pin_bit     = 16'd1 << i_in_data.pin_line;

    // stored reset values as they stand after this edge's config write
    always_comb begin
        cfg_mode  = r_mode_rv;
        cfg_speed = r_speed_rv;
        cfg_pull  = r_pull_rv;
        unique case (t_cfg_idx'(i_cfg_index))
            CFG_MODE_RST:  cfg_mode  = i_cfg_wdata;
            CFG_SPEED_RST: cfg_speed = i_cfg_wdata;
            CFG_PULL_RST:  cfg_pull  = i_cfg_wdata;
            default: ;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_otype  = r_otype;
        n_speed  = r_speed;
        n_pull   = r_pull;
        n_output = r_output;
        n_lock   = r_lock;
        n_afl    = r_afl;
        n_afh    = r_afh;
        n_ascr   = r_ascr;
        n_float  = r_float;
        n_dh     = r_dh;
        upd      = 1'b0;
        n_out.read_data = '0;
        n_out.status    = ST_OK;

        case (i_in_data.cmd)
            CMD_READ: begin
                unique case (i_in_data.reg_offset)
                    OFF_MODE:   n_out.read_data = r_mode;
                    OFF_OTYPE:  n_out.read_data = {16'd0, r_otype};
                    OFF_SPEED:  n_out.read_data = r_speed;
                    OFF_PULL:   n_out.read_data = r_pull;
                    OFF_INPUT:  n_out.read_data = {16'd0, r_input};
                    OFF_OUTPUT: n_out.read_data = {16'd0, r_output};
                    OFF_BSRR:   n_out.read_data = '0;
                    OFF_LOCK:   n_out.read_data = {16'd0, r_lock};
                    OFF_AFL:    n_out.read_data = r_afl;
                    OFF_AFH:    n_out.read_data = r_afh;
                    OFF_BRR:    n_out.read_data = '0;
                    OFF_ASCR:   n_out.read_data = {16'd0, r_ascr};
                    default:    n_out.status    = ST_BAD_OFF;
                endcase
            end
            CMD_WRITE: begin
                unique case (i_in_data.reg_offset)
                    OFF_MODE: begin
                        n_mode  = i_in_data.write_data;
                        n_float = r_float | f_conflicts(n_mode, r_otype, r_float, r_dh);
                        upd     = 1'b1;
                    end
                    OFF_OTYPE: begin
                        n_otype = i_in_data.write_data[15:0];
                        n_float = r_float | f_conflicts(r_mode, n_otype, r_float, r_dh);
                        upd     = 1'b1;
                    end
                    OFF_SPEED: n_speed = i_in_data.write_data;
                    OFF_PULL: begin
                        n_pull = i_in_data.write_data;
                        upd    = 1'b1;
                    end
                    OFF_INPUT: ;
                    OFF_OUTPUT: begin
                        n_output = i_in_data.write_data[15:0];
                        upd      = 1'b1;
                    end
                    OFF_BSRR: begin
                        // set wins over reset
                        n_output = (r_output & ~i_in_data.write_data[31:16])
                                 | i_in_data.write_data[15:0];
                        upd      = 1'b1;
                    end
                    OFF_LOCK:  n_lock = i_in_data.write_data[15:0];
                    OFF_AFL:   n_afl  = i_in_data.write_data;
                    OFF_AFH:   n_afh  = i_in_data.write_data;
                    OFF_BRR: begin
                        n_output = r_output & ~i_in_data.write_data[15:0];
                        upd      = 1'b1;
                    end
                    OFF_ASCR:  n_ascr = i_in_data.write_data[15:0];
                    default:   n_out.status = ST_BAD_OFF;
                endcase
            end
            CMD_DRIVE: begin
                // only an open-drain output may be pulled low from outside
                if ({1'b0, i_in_data.pin_line} >= 5'(NUM_PINS)
                    || (r_mode[{i_in_data.pin_line, 1'b0} +: 2] == MODE_OUTPUT
                        && !(r_otype[i_in_data.pin_line] && !i_in_data.pin_level))) begin
                    n_out.status = ST_REFUSED;
                end else begin
                    n_float = r_float & ~pin_bit;
                    n_dh    = i_in_data.pin_level ? (r_dh | pin_bit) : (r_dh & ~pin_bit);
                    upd     = 1'b1;
                end
            end
            default: begin
                n_float = r_float | i_in_data.disconnect_mask;
                upd     = 1'b1;
            end
        endcase

        n_input = upd ? f_refresh(n_mode, n_otype, n_pull, n_output, n_float, n_dh, r_input)
                      : r_input;
        n_out.rise_pins = n_input & ~r_input & PinMask;
        n_out.fall_pins = ~n_input & r_input & PinMask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_rv   <= '0;
            r_speed_rv  <= '0;
            r_pull_rv   <= '0;
            r_mode      <= '0;
            r_otype     <= '0;
            r_speed     <= '0;
            r_pull      <= '0;
            r_input     <= '0;
            r_output    <= '0;
            r_lock      <= '0;
            r_afl       <= '0;
            r_afh       <= '0;
            r_ascr      <= '0;
            r_float     <= '1;
            r_dh        <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            // store the reset values; any index but CFG_NONE also reloads the port from them
            r_mode_rv  <= cfg_mode;
            r_speed_rv <= cfg_speed;
            r_pull_rv  <= cfg_pull;
            if (i_cfg_index != CFG_NONE) begin
                r_mode   <= cfg_mode;
                r_otype  <= '0;
                r_speed  <= cfg_speed;
                r_pull   <= cfg_pull;
                r_input  <= f_refresh(cfg_mode, 16'd0, cfg_pull, 16'd0, '1, 16'd0, 16'd0);
                r_output <= '0;
                r_lock   <= '0;
                r_afl    <= '0;
                r_afh    <= '0;
                r_ascr   <= '0;
                r_float  <= '1;
                r_dh     <= '0;
            end
        end else begin
            if (in_acc) begin
                r_mode   <= n_mode;
                r_otype  <= n_otype;
                r_speed  <= n_speed;
                r_pull   <= n_pull;
                r_input  <= n_input;
                r_output <= n_output;
                r_lock   <= n_lock;
                r_afl    <= n_afl;
                r_afh    <= n_afh;
                r_ascr   <= n_ascr;
                r_float  <= n_float;
                r_dh     <= n_dh;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    `GP_ASSERT(a_read_no_edges, i_clk, i_rst_n,
        (in_acc && !i_cfg_we && i_in_data.cmd == CMD_READ) |=>
        (r_out.rise_pins == 16'd0 && r_out.fall_pins == 16'd0))
    `GP_ASSERT(a_nonread_zero_data, i_clk, i_rst_n,
        (in_acc && !i_cfg_we && i_in_data.cmd != CMD_READ) |=> (r_out.read_data == 32'd0))
    `GP_ASSERT(a_bad_pin_refused, i_clk, i_rst_n,
        (in_acc && !i_cfg_we && i_in_data.cmd == CMD_DRIVE
         && {1'b0, i_in_data.pin_line} >= 5'(NUM_PINS)) |=> (r_out.status == ST_REFUSED))
    `GP_ASSERT(a_edges_match_input, i_clk, i_rst_n,
        r_out_valid |-> ((r_out.rise_pins & ~r_input) == 16'd0
                         && (r_out.fall_pins & r_input) == 16'd0))
    `GP_ASSERT_ALWAYS(a_cfg_reloads, i_clk,
        (i_rst_n && i_cfg_we && i_cfg_index != CFG_NONE) |=>
        (r_float == 16'hFFFF && r_dh == 16'd0))

endmodule

`default_nettype wire

/* dv/gpio_port_with_open_drain_pulls_unit_tb.sv */
`timescale 1ns / 100ps

module gpio_port_with_open_drain_pulls_unit_tb;
    import gpodp_pkg::*;

    localparam int PINS        = 16;
    localparam int PHASE_ITEMS = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_PCT    = 34;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_NONE;
    logic [31:0] i_cfg_wdata = '0;

    gpio_port_with_open_drain_pulls_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Port model state
    logic [31:0] mode_dflt  = '0;
    logic [31:0] speed_dflt = '0;
    logic [31:0] pull_dflt  = '0;
    logic [31:0] mode_r, speed_r, pull_r, afl_r, afh_r;
    logic [15:0] otype_r, idr_r, odr_r, lock_r, ascr_r, undriven_r, ext_high_r;

    t_in_item  pending_reqs[$];
    t_out_item port_results_q[$];
    bit        req_taken         = 1'b0;
    bit        calm              = 1'b0;
    int        hold_off_requests = 0;
    int        hold_off_seen     = 0;
    int        hold_off_left     = 0;
    int        errors            = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void refresh_pin_levels();
        logic [15:0] lvl;
        logic [1:0]  pl;
        bit          ext;
        lvl = idr_r;
        for (int p = 0; p < PINS; p++) begin
            pl  = pull_r[2*p +: 2];
            ext = !undriven_r[p];
            if (mode_r[2*p +: 2] == MODE_OUTPUT) begin
                if (!otype_r[p] || !odr_r[p]) begin
                    lvl[p] = odr_r[p];
                end else if (ext && !ext_high_r[p]) begin
                    lvl[p] = 1'b0;
                end else if (pl == PULL_UP) begin
                    lvl[p] = 1'b1;
                end else if (pl == PULL_DOWN) begin
                    lvl[p] = 1'b0;
                end
            end else if (ext) begin
                lvl[p] = ext_high_r[p];
            end else if (pl == PULL_UP) begin
                lvl[p] = 1'b1;
            end else if (pl == PULL_DOWN) begin
                lvl[p] = 1'b0;
            end
        end
        idr_r = lvl;
    endfunction

    // Pins driven from outside that now fight an output
    function automatic logic [15:0] conflict_mask();
        logic [15:0] m;
        m = '0;
        for (int p = 0; p < PINS; p++) begin
            if (!undriven_r[p] && mode_r[2*p +: 2] == MODE_OUTPUT &&
                (!otype_r[p] || ext_high_r[p]))
                m[p] = 1'b1;
        end
        return m;
    endfunction

    function automatic void load_port_defaults();
        mode_r     = mode_dflt;
        otype_r    = '0;
        speed_r    = speed_dflt;
        pull_r     = pull_dflt;
        idr_r      = '0;
        odr_r      = '0;
        lock_r     = '0;
        afl_r      = '0;
        afh_r      = '0;
        ascr_r     = '0;
        undriven_r = '1;
        ext_high_r = '0;
        refresh_pin_levels();
    endfunction

    function automatic t_out_item apply_request(input t_in_item rq);
        t_out_item   rs;
        logic [15:0] prev_idr;
        bit          upd;
        rs       = '0;
        rs.status = ST_OK;
        prev_idr = idr_r;
        upd      = 1'b0;
        case (rq.cmd)
            CMD_READ: begin
                case (rq.reg_offset)
                    OFF_MODE:   rs.read_data = mode_r;
                    OFF_OTYPE:  rs.read_data = {16'h0, otype_r};
                    OFF_SPEED:  rs.read_data = speed_r;
                    OFF_PULL:   rs.read_data = pull_r;
                    OFF_INPUT:  rs.read_data = {16'h0, idr_r};
                    OFF_OUTPUT: rs.read_data = {16'h0, odr_r};
                    OFF_BSRR:   rs.read_data = '0;
                    OFF_LOCK:   rs.read_data = {16'h0, lock_r};
                    OFF_AFL:    rs.read_data = afl_r;
                    OFF_AFH:    rs.read_data = afh_r;
                    OFF_BRR:    rs.read_data = '0;
                    OFF_ASCR:   rs.read_data = {16'h0, ascr_r};
                    default:    rs.status = ST_BAD_OFF;
                endcase
            end
            CMD_WRITE: begin
                case (rq.reg_offset)
                    OFF_MODE: begin
                        mode_r = rq.write_data;
                        undriven_r |= conflict_mask();
                        upd = 1'b1;
                    end
                    OFF_OTYPE: begin
                        otype_r = rq.write_data[15:0];
                        undriven_r |= conflict_mask();
                        upd = 1'b1;
                    end
                    OFF_SPEED: speed_r = rq.write_data;
                    OFF_PULL: begin
                        pull_r = rq.write_data;
                        upd = 1'b1;
                    end
                    OFF_INPUT: ;
                    OFF_OUTPUT: begin
                        odr_r = rq.write_data[15:0];
                        upd = 1'b1;
                    end
                    OFF_BSRR: begin
                        // clear first so that set wins
                        odr_r = (odr_r & ~rq.write_data[31:16]) | rq.write_data[15:0];
                        upd = 1'b1;
                    end
                    OFF_LOCK: lock_r = rq.write_data[15:0];
                    OFF_AFL:  afl_r = rq.write_data;
                    OFF_AFH:  afh_r = rq.write_data;
                    OFF_BRR: begin
                        odr_r &= ~rq.write_data[15:0];
                        upd = 1'b1;
                    end
                    OFF_ASCR: ascr_r = rq.write_data[15:0];
                    default:  rs.status = ST_BAD_OFF;
                endcase
            end
            CMD_DRIVE: begin
                if (mode_r[2*rq.pin_line +: 2] == MODE_OUTPUT &&
                    !(otype_r[rq.pin_line] && !rq.pin_level)) begin
                    rs.status = ST_REFUSED;
                end else begin
                    undriven_r[rq.pin_line] = 1'b0;
                    ext_high_r[rq.pin_line] = rq.pin_level;
                    upd = 1'b1;
                end
            end
            CMD_DISCONNECT: begin
                undriven_r |= rq.disconnect_mask;
                upd = 1'b1;
            end
        endcase
        if (upd)
            refresh_pin_levels();
        rs.rise_pins = idr_r & ~prev_idr;
        rs.fall_pins = ~idr_r & prev_idr;
        return rs;
    endfunction

    function automatic logic [9:0] port_offset(input int k);
        case (k)
            0:       return OFF_MODE;
            1:       return OFF_OTYPE;
            2:       return OFF_SPEED;
            3:       return OFF_PULL;
            4:       return OFF_INPUT;
            5:       return OFF_OUTPUT;
            6:       return OFF_BSRR;
            7:       return OFF_LOCK;
            8:       return OFF_AFL;
            9:       return OFF_AFH;
            10:      return OFF_BRR;
            default: return OFF_ASCR;
        endcase
    endfunction

    function automatic t_in_item mk_req(input t_cmd c, input logic [9:0] off,
                                        input logic [31:0] wd, input logic [3:0] line,
                                        input logic lvl, input logic [15:0] mask);
        t_in_item rq;
        rq.cmd             = c;
        rq.reg_offset      = off;
        rq.write_data      = wd;
        rq.pin_line        = line;
        rq.pin_level       = lvl;
        rq.disconnect_mask = mask;
        return rq;
    endfunction

    function automatic t_in_item rand_request();
        t_in_item rq;
        int       pick;
        rq.reg_offset      = 10'($urandom_range(1023));
        rq.write_data      = $urandom();
        rq.pin_line        = 4'($urandom_range(PINS - 1));
        rq.pin_level       = 1'($urandom_range(1));
        rq.disconnect_mask = 16'($urandom());
        pick = $urandom_range(99);
        if (pick < 30)
            rq.cmd = CMD_READ;
        else if (pick < 65)
            rq.cmd = CMD_WRITE;
        else if (pick < 90)
            rq.cmd = CMD_DRIVE;
        else
            rq.cmd = CMD_DISCONNECT;
        // mostly legal offsets, the rest anywhere in the window
        if ((rq.cmd == CMD_READ || rq.cmd == CMD_WRITE) && $urandom_range(99) < 92)
            rq.reg_offset = port_offset($urandom_range(11));
        if (rq.cmd == CMD_DISCONNECT && $urandom_range(1))
            rq.disconnect_mask = 16'(1) << $urandom_range(PINS - 1);
        return rq;
    endfunction

    task automatic write_cfg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_MODE_RST:  mode_dflt = val;
            CFG_SPEED_RST: speed_dflt = val;
            CFG_PULL_RST:  pull_dflt = val;
            default: ;
        endcase
        if (idx != CFG_NONE)
            load_port_defaults();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_in_valid || port_results_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_reqs.push_back(rand_request());
    endtask

    // Request driver
    always @(negedge i_clk) begin
        if (!i_in_valid || req_taken) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_reqs.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver
    always @(negedge i_clk) begin
        if (hold_off_seen != hold_off_requests) begin
            hold_off_seen = hold_off_requests;
            hold_off_left = HOLD_CYCLES;
        end
        if (hold_off_left > 0) begin
            i_out_stall <= 1'b1;
            hold_off_left--;
        end else begin
            i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Monitor: check the result first, then predict the request taken at this edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (port_results_q.size() == 0) begin
                    flag_error($sformatf("result %h with no request pending", o_out_data));
                end else begin
                    want = port_results_q.pop_front();
                    if (o_out_data.read_data !== want.read_data)
                        flag_error($sformatf("read_data %h, want %h",
                                             o_out_data.read_data, want.read_data));
                    if (o_out_data.rise_pins !== want.rise_pins)
                        flag_error($sformatf("rise_pins %h, want %h",
                                             o_out_data.rise_pins, want.rise_pins));
                    if (o_out_data.fall_pins !== want.fall_pins)
                        flag_error($sformatf("fall_pins %h, want %h",
                                             o_out_data.fall_pins, want.fall_pins));
                    if (o_out_data.status !== want.status)
                        flag_error($sformatf("status %0d, want %0d",
                                             o_out_data.status, want.status));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                port_results_q.push_back(apply_request(i_in_data));
                req_taken <= 1'b1;
            end else begin
                req_taken <= 1'b0;
            end
        end
    end

    initial begin
        load_port_defaults();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed pass on reset defaults
        pending_reqs.push_back(mk_req(CMD_READ, OFF_INPUT, '0, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_DRIVE, 10'h3FF, 32'hFFFF_FFFF, 4'd3, 1'b1, '1));
        pending_reqs.push_back(mk_req(CMD_DRIVE, '0, '0, 4'd4, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_DRIVE, '0, '0, 4'd15, 1'b1, '0));
        // all outputs: push-pull pins drop their outside drive
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_MODE, 32'h5555_5555, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_OTYPE, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_OUTPUT, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_DRIVE, '0, '0, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_DRIVE, '0, '0, 4'd1, 1'b1, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_PULL, 32'h5555_5555, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_PULL, 32'hAAAA_AAAA, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_PULL, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_BSRR, 32'hFFFF_0000, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_BSRR, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_BRR, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_INPUT, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_LOCK, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_AFL, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_AFH, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_ASCR, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, OFF_SPEED, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_READ, OFF_BSRR, '0, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_READ, 10'h3FC, '0, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_WRITE, 10'h002, 32'hFFFF_FFFF, 4'd0, 1'b0, '0));
        pending_reqs.push_back(mk_req(CMD_DISCONNECT, '0, '0, 4'd0, 1'b0, 16'hFFFF));
        wait_drained();

        // extremes of the reset values
        write_cfg(CFG_MODE_RST, 32'hFFFF_FFFF);
        write_cfg(CFG_SPEED_RST, 32'hFFFF_FFFF);
        write_cfg(CFG_PULL_RST, 32'h5555_5555);
        queue_random(PHASE_ITEMS);
        wait_drained();

        // all outputs, pull-down, no idling on either side
        write_cfg(CFG_MODE_RST, 32'h5555_5555);
        write_cfg(CFG_PULL_RST, 32'hAAAA_AAAA);
        calm = 1'b1;
        queue_random(PHASE_ITEMS);
        wait_drained();
        calm = 1'b0;

        // hold results back while requests keep coming
        write_cfg(CFG_MODE_RST, $urandom());
        write_cfg(CFG_SPEED_RST, $urandom());
        write_cfg(CFG_PULL_RST, $urandom());
        queue_random(PHASE_ITEMS);
        hold_off_requests++;
        wait_drained();

        write_cfg(CFG_NONE, 32'hFFFF_FFFF);
        write_cfg(CFG_MODE_RST, 32'h0000_0000);
        write_cfg(CFG_PULL_RST, 32'hFFFF_FFFF);
        queue_random(PHASE_ITEMS);
        wait_drained();

        write_cfg(CFG_PULL_RST, $urandom());
        write_cfg(CFG_MODE_RST, $urandom());
        queue_random(PHASE_ITEMS);
        wait_drained();

        write_cfg(CFG_MODE_RST, 32'h0000_0000);
        write_cfg(CFG_SPEED_RST, 32'h0000_0000);
        write_cfg(CFG_PULL_RST, 32'h0000_0000);
        queue_random(PHASE_ITEMS);
        wait_drained();

        repeat (8) @(negedge i_clk);
        if (errors == 0 && port_results_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
